// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define KSA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define KSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ksa_pkg.sv =====
// ---------------------------------------------------------------------------
// ksa_pkg
// Types, scan code constants and key tables for the scan code decoder.
// ---------------------------------------------------------------------------
package ksa_pkg;

    localparam logic [7:0] BYTE_PAUSE    = 8'he1;
    localparam logic [7:0] BYTE_EXTENDED = 8'he0;
    localparam logic [6:0] CODE_LSHIFT   = 7'h2a;
    localparam logic [6:0] CODE_RSHIFT   = 7'h36;
    localparam logic [6:0] CODE_CAPS     = 7'h3a;
    localparam logic [6:0] CODE_ENTER    = 7'h1c;
    localparam logic [6:0] CODE_SLASH    = 7'h35;
    localparam logic [2:0] PAUSE_SKIP    = 3'd5;

    localparam logic [6:0] CHAR_NEWLINE  = 7'h0a;
    localparam logic [6:0] CHAR_SLASH    = 7'h2f;
    localparam logic [6:0] CHAR_LC_A     = 7'h61;
    localparam logic [6:0] CHAR_LC_Z     = 7'h7a;
    localparam logic [6:0] CASE_OFFSET   = 7'h20;

    // Scan byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] scan;
    } ksa_in_t;

    // Decode result offered to the output register
    typedef struct packed {
        logic       valid;
        logic [6:0] ch;
    } ksa_res_t;

    // US layout, unshifted; zero marks an unmapped code
    function automatic logic [6:0] ksa_base_map(input logic [6:0] code);
        logic [6:0] ch;
        case (code)
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0a: ch = 7'h39;
            7'h0b: ch = 7'h30;
            7'h0c: ch = 7'h2d;
            7'h0d: ch = 7'h3d;
            7'h0e: ch = 7'h08;
            7'h0f: ch = 7'h09;
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6f;
            7'h19: ch = 7'h70;
            7'h1a: ch = 7'h5b;
            7'h1b: ch = 7'h5d;
            7'h1c: ch = 7'h0a;
            7'h1e: ch = 7'h61;
            7'h1f: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6a;
            7'h25: ch = 7'h6b;
            7'h26: ch = 7'h6c;
            7'h27: ch = 7'h3b;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2b: ch = 7'h5c;
            7'h2c: ch = 7'h7a;
            7'h2d: ch = 7'h78;
            7'h2e: ch = 7'h63;
            7'h2f: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6e;
            7'h32: ch = 7'h6d;
            7'h33: ch = 7'h2c;
            7'h34: ch = 7'h2e;
            7'h35: ch = 7'h2f;
            7'h37: ch = 7'h2a;
            7'h39: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // US layout, shifted symbols; zero means keep the unshifted entry
    function automatic logic [6:0] ksa_upper_map(input logic [6:0] code);
        logic [6:0] ch;
        case (code)
            7'h02: ch = 7'h21;
            7'h03: ch = 7'h40;
            7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;
            7'h06: ch = 7'h25;
            7'h07: ch = 7'h5e;
            7'h08: ch = 7'h26;
            7'h09: ch = 7'h2a;
            7'h0a: ch = 7'h28;
            7'h0b: ch = 7'h29;
            7'h0c: ch = 7'h5f;
            7'h0d: ch = 7'h2b;
            7'h1a: ch = 7'h7b;
            7'h1b: ch = 7'h7d;
            7'h27: ch = 7'h3a;
            7'h28: ch = 7'h22;
            7'h29: ch = 7'h7e;
            7'h2b: ch = 7'h7c;
            7'h33: ch = 7'h3c;
            7'h34: ch = 7'h3e;
            7'h35: ch = 7'h3f;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/ksa_in_stage.sv =====
// ---------------------------------------------------------------------------
// ksa_in_stage
// Input register: captures one scan byte per request.
// ---------------------------------------------------------------------------
module ksa_in_stage
    import ksa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] scan_byte
    input  logic       advance,
    output ksa_in_t    held
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] scan_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            scan_reg <= s_tdata;
        end
    end

    assign held.valid = valid_reg;
    assign held.scan  = scan_reg;

endmodule

// ===== rtl/ksa_decode.sv =====
// ---------------------------------------------------------------------------
// ksa_decode
// Modifier state and one-pass translation of a scan byte to ASCII.
// ---------------------------------------------------------------------------
module ksa_decode
    import ksa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ksa_in_t  held,
    input  logic     advance,
    output ksa_res_t res
);

    logic       ext_reg,    ext_next;
    logic       lshift_reg, lshift_next;
    logic       rshift_reg, rshift_next;
    logic       caps_reg,   caps_next;
    logic       capkey_reg, capkey_next;
    logic [2:0] pause_reg,  pause_next;

    logic       released;
    logic [6:0] code;
    logic [6:0] base_ch;
    logic [6:0] upper_ch;
    logic       shift;

    assign released = held.scan[7];
    assign code     = held.scan[6:0];
    assign base_ch  = ksa_base_map(code);
    assign upper_ch = ksa_upper_map(code);
    assign shift    = lshift_reg || rshift_reg;

    always_comb
    begin
        ext_next    = ext_reg;
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        caps_next   = caps_reg;
        capkey_next = capkey_reg;
        pause_next  = pause_reg;
        res.valid   = 1'b0;
        res.ch      = base_ch;

        if (pause_reg != 3'd0)
        begin
            pause_next = pause_reg - 3'd1;
        end
        else if (held.scan == BYTE_PAUSE)
        begin
            pause_next = PAUSE_SKIP;
            ext_next   = 1'b0;
        end
        else if (held.scan == BYTE_EXTENDED)
        begin
            ext_next = 1'b1;
        end
        else if (ext_reg)
        begin
            // only keypad enter and keypad slash survive the prefix
            ext_next = 1'b0;
            if (!released && (code == CODE_ENTER || code == CODE_SLASH))
            begin
                res.valid = 1'b1;
                res.ch    = (code == CODE_ENTER) ? CHAR_NEWLINE : CHAR_SLASH;
            end
        end
        else if (code == CODE_LSHIFT)
        begin
            lshift_next = !released;
        end
        else if (code == CODE_RSHIFT)
        begin
            rshift_next = !released;
        end
        else if (code == CODE_CAPS)
        begin
            if (!released && !capkey_reg)
            begin
                caps_next = !caps_reg;
            end
            capkey_next = !released;
        end
        else if (!released && base_ch != 7'd0)
        begin
            res.valid = 1'b1;
            if (base_ch inside {[CHAR_LC_A:CHAR_LC_Z]})
            begin
                if (shift != caps_reg)
                begin
                    res.ch = base_ch - CASE_OFFSET;
                end
            end
            else if (shift && upper_ch != 7'd0)
            begin
                res.ch = upper_ch;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg    <= 1'b0;
            lshift_reg <= 1'b0;
            rshift_reg <= 1'b0;
            caps_reg   <= 1'b0;
            capkey_reg <= 1'b0;
            pause_reg  <= 3'd0;
        end
        else if (advance)
        begin
            ext_reg    <= ext_next;
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
            caps_reg   <= caps_next;
            capkey_reg <= capkey_next;
            pause_reg  <= pause_next;
        end
    end

endmodule

// ===== rtl/ksa_out_stage.sv =====
// ---------------------------------------------------------------------------
// ksa_out_stage
// Result register on the master side; takes a new result while one drains.
// ---------------------------------------------------------------------------
module ksa_out_stage
    import ksa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ksa_res_t   res,
    input  logic       advance,
    output logic       take,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [6:0] ascii_char, [7] zero
);

    logic       valid_reg;
    logic       valid_next;
    logic [6:0] ch_reg;

    assign take = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res.valid;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            ch_reg <= res.ch;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, ch_reg};

endmodule

// ===== rtl/keyboard_scancode_to_ascii.sv =====
// ---------------------------------------------------------------------------
// keyboard_scancode_to_ascii: scan code set 1 to ASCII decoder
// Request to result passes the input register, then the result register.
// Throughput one byte per cycle; only a stalled result register holds input.
// Reset clears the modifier, prefix and pause state and empties both stages.
// ---------------------------------------------------------------------------
module keyboard_scancode_to_ascii
    import ksa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] scan_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [6:0] ascii_char, [7] zero
);

    ksa_in_t  held;
    ksa_res_t res;
    logic     take;
    logic     advance;

    // byte leaves the input register whether or not it yields a result
    assign advance = held.valid && take;

    ksa_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .held     (held)
    );

    ksa_decode u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .held    (held),
        .advance (advance),
        .res     (res)
    );

    ksa_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .advance  (advance),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/ksa_checker.sv =====
// ---------------------------------------------------------------------------
// ksa_checker
// Port-level checks on the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ksa_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // with the result register empty the pipe can always move
    `KSA_ASSERT(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with output empty")

    // results are 7-bit ASCII
    `KSA_ASSERT(a_ascii_range, m_tvalid, m_tdata[7] == 1'b0, "result above 7 bits")

    // a pending byte cannot be taken while a stalled result blocks the pipe twice
    `KSA_ASSERT_NEXT(a_stall_backs_up, m_tvalid && !m_tready && !s_tready,
        !s_tready || m_tready, "input taken during output stall")

    `KSA_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind keyboard_scancode_to_ascii ksa_checker u_ksa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
